// ===== rtl/core/pdq_pkg.sv =====
// shared constants, types and helpers for the possibility degree query block
package pdq_pkg;

   localparam int LANES      = 4;
   localparam int LANE_BITS  = $clog2(LANES);
   localparam int MAX_ENTRIES = 256;
   localparam int ROWS       = MAX_ENTRIES / LANES;
   localparam int ROW_BITS   = $clog2(ROWS);
   localparam int COLS       = 8;
   localparam int VB         = 4;
   localparam int DOM        = 1 << VB;
   localparam int WB         = 16;
   localparam int TB         = COLS * VB;
   localparam logic [VB-1:0] NULL_CODE = '1;

   typedef enum logic [1:0] {
      REG_ENTRIES_IN_USE = 2'd0,
      REG_COLUMN_COUNT   = 2'd1,
      REG_VALUE_COUNTS   = 2'd2
   } pdq_reg_type;

   typedef logic [COLS-1:0][DOM-1:0] pdq_seen_type;

   typedef struct packed {
      logic [COLS-1:0] care;
      logic [COLS-1:0] other;
      logic [TB-1:0]   target;
   } pdq_match_type;

   function automatic logic [VB-1:0] low_bit(input logic [DOM-1:0] m);
      logic [VB-1:0] r;
      r = '0;
      for (int i = DOM - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = VB'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/possibility_degree_query.sv =====
// possibility degree query top level: table, filling walk, accumulation and divide
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   mode, entry_index, tuple_values, weight
//  rsp      out  rsp_valid/rsp_stall   average/minimum/maximum_possibility, filling_count
//  csr      in   csr_valid/csr_ready   index, data
//
// a write request leaves the block idle; a query scans the table rows once to collect seen
// values and then once per filling group, rows = ceil(entries/4) over the four table lanes,
// filling groups = product over null columns of seen values plus one unseen class if any remain
// reset clears control and loads default configuration; the table is undefined until written
// a finished result waits in the output register while the next request is accepted
module possibility_degree_query (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_tuple_values,
   input  logic [15:0] req_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_average_possibility,
   output logic [15:0] rsp_minimum_possibility,
   output logic [15:0] rsp_maximum_possibility,
   output logic [31:0] rsp_filling_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pdq_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_SCAN = 9'b000000010,
      ST_MASK = 9'b000000100,
      ST_MULT = 9'b000001000,
      ST_REC  = 9'b000010000,
      ST_ACC  = 9'b000100000,
      ST_DIV  = 9'b001000000,
      ST_OUT  = 9'b010000000,
      ST_WAIT = 9'b100000000
   } pdq_state_type;

   pdq_state_type st_ff, st_in;

   logic [8:0]  eiu_ff;
   logic [3:0]  ccnt_ff;
   logic [31:0] vcnt_ff;
   logic [TB-1:0] q_ff;
   logic        walk_ff, walk_in;
   logic [ROW_BITS:0] row_ff, row_in;
   logic [1:0]  drain_ff, drain_in;
   logic [COLS-1:0] nul_ff, nul_in;
   logic [COLS-1:0][DOM-1:0] mask_ff, mask_in;
   logic [COLS-1:0][VB-1:0]  othc_ff, othc_in;
   logic [COLS-1:0][VB-1:0]  cls_ff, cls_in;
   logic [$clog2(COLS)-1:0]  mk_ff, mk_in;
   logic [31:0] mult_ff, mult_in;
   logic [WB-1:0] p_ff, p_in;
   logic [47:0] prod_ff, prod_in;
   logic [47:0] sum_ff, sum_in;
   logic [31:0] count_ff, count_in;
   logic [WB-1:0] min_ff, min_in, max_ff, max_in;
   logic [47:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] avg_o_ff, avg_o_in, min_o_ff, min_o_in, max_o_ff, max_o_in;
   logic [31:0] cnt_o_ff, cnt_o_in;

   logic [8:0]  used;
   logic [ROW_BITS:0] rows;
   logic [3:0]  cols;
   logic        accept, clear, rd_en, odo_done;
   logic [COLS-1:0][VB-1:0] cls_next;
   pdq_match_type match;
   logic [LANES-1:0] lane_wr, hit;
   logic [LANES-1:0][WB-1:0] hit_weight;
   pdq_seen_type hit_seen [LANES];
   logic [WB-1:0] best;
   pdq_seen_type  seen;
   logic [32:0] trial;
   logic [VB-1:0] fac;

   assign used = (eiu_ff > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : eiu_ff;
   assign rows = (ROW_BITS+1)'((10'(used) + 10'(LANES - 1)) >> LANE_BITS);
   assign cols = (ccnt_ff > 4'(COLS)) ? 4'(COLS) : ccnt_ff;
   assign req_stall = (st_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rd_en = (st_ff == ST_SCAN) && (row_ff < rows);
   assign clear = (accept && req_mode) || (st_ff == ST_MULT && mk_ff == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff  <= '0;
         ccnt_ff <= 4'd8;
         vcnt_ff <= 32'h22222222;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ENTRIES_IN_USE: eiu_ff  <= csr_data[8:0];
            REG_COLUMN_COUNT:   ccnt_ff <= csr_data[3:0];
            REG_VALUE_COUNTS:   vcnt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      match = '0;
      for (int k = 0; k < COLS; k++) begin
         if (4'(k) < cols) begin
            if (!walk_ff) begin
               match.care[k] = q_ff[k*VB +: VB] != NULL_CODE;
               match.target[k*VB +: VB] = q_ff[k*VB +: VB];
            end else begin
               match.care[k] = 1'b1;
               match.other[k] = nul_ff[k] && cls_ff[k] == NULL_CODE;
               match.target[k*VB +: VB] = nul_ff[k] ? cls_ff[k] : q_ff[k*VB +: VB];
            end
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign lane_wr[l] = accept && !req_mode && req_entry_index[LANE_BITS-1:0] == LANE_BITS'(l);
      pdq_lane u_lane (
         .clock      (clock),
         .wr_en      (lane_wr[l]),
         .wr_addr    (req_entry_index[LANE_BITS +: ROW_BITS]),
         .wr_value   (req_tuple_values),
         .wr_weight  (req_weight),
         .rd_en      (rd_en && {row_ff[ROW_BITS-1:0], LANE_BITS'(l)} < used),
         .rd_addr    (row_ff[ROW_BITS-1:0]),
         .match      (match),
         .hit        (hit[l]),
         .hit_weight (hit_weight[l]),
         .hit_seen   (hit_seen[l])
      );
   end

   pdq_merge u_merge (
      .clock      (clock),
      .clear      (clear),
      .hit        (hit),
      .hit_weight (hit_weight),
      .hit_seen   (hit_seen),
      .best       (best),
      .seen       (seen)
   );

   always_comb begin
      logic [DOM-1:0] dm, sm, above;
      logic [VB-1:0]  dom, known;
      logic           adv;
      for (int k = 0; k < COLS; k++) begin
         dom = vcnt_ff[k*VB +: VB];
         dm  = DOM'((17'd1 << dom) - 17'd1);
         sm  = seen[k] & dm;
         sm[DOM-1] = 1'b0;
         known = VB'($countones(sm));
         nul_in[k]  = 4'(k) < cols && q_ff[k*VB +: VB] == NULL_CODE;
         othc_in[k] = ((dom == '0) ? VB'(1) : dom) - known;
         mask_in[k] = nul_in[k] ? {othc_in[k] != '0, sm[DOM-2:0]} : DOM'(1);
      end
      adv = 1'b1;
      for (int k = 0; k < COLS; k++) begin
         above = mask_ff[k] & ~DOM'((17'd2 << cls_ff[k]) - 17'd1);
         cls_next[k] = cls_ff[k];
         if (adv) begin
            if (above != '0) begin
               cls_next[k] = low_bit(above);
               adv = 1'b0;
            end else begin
               cls_next[k] = low_bit(mask_ff[k]);
            end
         end
      end
      odo_done = adv;
   end

   assign fac = (nul_ff[mk_ff] && cls_ff[mk_ff] == NULL_CODE) ? othc_ff[mk_ff] : VB'(1);
   assign trial = {rem_ff, num_ff[47]};

   always_comb begin
      st_in = st_ff;
      walk_in = walk_ff;
      row_in = row_ff;
      drain_in = drain_ff;
      mk_in = mk_ff;
      mult_in = mult_ff;
      p_in = p_ff;
      prod_in = prod_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      min_in = min_ff;
      max_in = max_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      cls_in = cls_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      avg_o_in = avg_o_ff;
      min_o_in = min_o_ff;
      max_o_in = max_o_ff;
      cnt_o_in = cnt_o_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept && req_mode) begin
               st_in = ST_SCAN;
               walk_in = 1'b0;
               row_in = '0;
               drain_in = '0;
               sum_in = '0;
               count_in = '0;
               min_in = '1;
               max_in = '0;
            end
         end
         ST_SCAN: begin
            if (row_ff < rows) begin
               row_in = row_ff + 1'b1;
            end else if (drain_ff != 2'd2) begin
               drain_in = drain_ff + 1'b1;
            end else if (!walk_ff) begin
               st_in = ST_MASK;
            end else begin
               p_in = best;
               st_in = ST_REC;
            end
         end
         ST_MASK: begin
            for (int k = 0; k < COLS; k++) begin
               cls_in[k] = low_bit(mask_in[k]);
            end
            mult_in = 32'd1;
            mk_in = '0;
            st_in = ST_MULT;
         end
         ST_MULT: begin
            mult_in = 32'(mult_ff * fac);
            mk_in = mk_ff + 1'b1;
            if (mk_ff == '1) begin
               st_in = ST_SCAN;
               walk_in = 1'b1;
               row_in = '0;
               drain_in = '0;
            end
         end
         ST_REC: begin
            prod_in = 48'(p_ff) * 48'(mult_ff);
            count_in = count_ff + mult_ff;
            if (p_ff < min_ff) min_in = p_ff;
            if (p_ff > max_ff) max_in = p_ff;
            st_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in = sum_ff + prod_ff;
            if (odo_done) begin
               num_in = sum_ff + prod_ff;
               rem_in = '0;
               dcnt_in = '0;
               st_in = ST_DIV;
            end else begin
               cls_in = cls_next;
               mult_in = 32'd1;
               mk_in = '0;
               st_in = ST_MULT;
            end
         end
         ST_DIV: begin
            if (trial >= {1'b0, count_ff}) begin
               rem_in = 32'(trial - {1'b0, count_ff});
               num_in = {num_ff[46:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               num_in = {num_ff[46:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 6'd47) st_in = ST_OUT;
         end
         ST_OUT: begin
            st_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               avg_o_in = (count_ff == '0) ? '0 : num_ff[15:0];
               min_o_in = (max_ff == '0) ? '0 : min_ff;
               max_o_in = max_ff;
               cnt_o_in = count_ff;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         walk_ff <= 1'b0;
         row_ff <= '0;
         drain_ff <= '0;
         mk_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff <= walk_in;
         row_ff <= row_in;
         drain_ff <= drain_in;
         mk_ff <= mk_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode) q_ff <= req_tuple_values;
      if (st_ff == ST_MASK) begin
         nul_ff  <= nul_in;
         mask_ff <= mask_in;
         othc_ff <= othc_in;
      end
      cls_ff <= cls_in;
      mult_ff <= mult_in;
      p_ff <= p_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      count_ff <= count_in;
      min_ff <= min_in;
      max_ff <= max_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      avg_o_ff <= avg_o_in;
      min_o_ff <= min_o_in;
      max_o_ff <= max_o_in;
      cnt_o_ff <= cnt_o_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_average_possibility = avg_o_ff;
   assign rsp_minimum_possibility = min_o_ff;
   assign rsp_maximum_possibility = max_o_ff;
   assign rsp_filling_count = cnt_o_ff;

   a_mult_nonzero: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_REC |-> mult_ff != '0)
      else $error("filling group with zero multiplicity");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_REC |=> count_ff > $past(count_ff))
      else $error("filling count did not grow");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_minimum_possibility <= rsp_maximum_possibility)
      else $error("minimum above maximum");

   a_avg_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_average_possibility <= rsp_maximum_possibility)
      else $error("average above maximum");

endmodule

// ===== rtl/core/pdq_lane.sv =====
// one lane: a bank of the entry table and the per-entry compatibility check
module pdq_lane (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [pdq_pkg::ROW_BITS-1:0]  wr_addr,
   input  logic [pdq_pkg::TB-1:0]        wr_value,
   input  logic [pdq_pkg::WB-1:0]        wr_weight,
   input  logic                          rd_en,
   input  logic [pdq_pkg::ROW_BITS-1:0]  rd_addr,
   input  pdq_pkg::pdq_match_type        match,
   output logic                          hit,
   output logic [pdq_pkg::WB-1:0]        hit_weight,
   output pdq_pkg::pdq_seen_type         hit_seen
);
   import pdq_pkg::*;

   logic [TB+WB-1:0] mem [ROWS];
   logic [TB+WB-1:0] rd_ff;
   logic             vld_ff;
   logic [COLS-1:0]  col_ok;
   logic [VB-1:0]    ek;
   logic [VB-1:0]    tk;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_value, wr_weight};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      vld_ff <= rd_en;
   end

   always_comb begin
      ek = '0;
      tk = '0;
      hit_seen = '0;
      for (int k = 0; k < COLS; k++) begin
         ek = rd_ff[WB + k*VB +: VB];
         tk = match.target[k*VB +: VB];
         col_ok[k] = !match.care[k] || ek == NULL_CODE || (!match.other[k] && ek == tk);
      end
      hit = vld_ff && (&col_ok);
      for (int k = 0; k < COLS; k++) begin
         ek = rd_ff[WB + k*VB +: VB];
         if (hit && ek != NULL_CODE) begin
            hit_seen[k][ek] = 1'b1;
         end
      end
      hit_weight = hit ? rd_ff[WB-1:0] : '0;
   end

endmodule

// ===== rtl/core/pdq_merge.sv =====
// merging stage: running maximum weight and seen values over all lanes
module pdq_merge (
   input  logic                                  clock,
   input  logic                                  clear,
   input  logic [pdq_pkg::LANES-1:0]             hit,
   input  logic [pdq_pkg::LANES-1:0][pdq_pkg::WB-1:0] hit_weight,
   input  pdq_pkg::pdq_seen_type                 hit_seen [pdq_pkg::LANES],
   output logic [pdq_pkg::WB-1:0]                best,
   output pdq_pkg::pdq_seen_type                 seen
);
   import pdq_pkg::*;

   logic [WB-1:0] best_ff, best_in;
   pdq_seen_type  seen_ff, seen_in;

   always_comb begin
      best_in = best_ff;
      seen_in = seen_ff;
      for (int l = 0; l < LANES; l++) begin
         if (hit[l] && hit_weight[l] > best_in) begin
            best_in = hit_weight[l];
         end
         seen_in = seen_in | hit_seen[l];
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         best_ff <= '0;
         seen_ff <= '0;
      end else begin
         best_ff <= best_in;
         seen_ff <= seen_in;
      end
   end

   assign best = best_ff;
   assign seen = seen_ff;

endmodule

// ===== tb/possibility_degree_query_test.sv =====
// self-checking testbench for the possibility degree query block
module possibility_degree_query_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pdq_pkg::*;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;
   localparam int CYCLE_LIMIT = 300000000;

   typedef struct packed {
      logic [15:0] average;
      logic [15:0] minimum;
      logic [15:0] maximum;
      logic [31:0] fillings;
   } degree_type;

   class degree_scoreboard;
      logic [31:0] tuples [256];
      logic [15:0] weights [256];
      logic [8:0]  entries_in_use = 0;
      logic [3:0]  column_count = 8;
      logic [31:0] value_counts = 32'h22222222;
      degree_type  pending [$];
      int          errors = 0;
      int          used, null_total;
      int          null_cols [8];
      longint unsigned rest_prod [9];
      longint unsigned acc_sum, acc_count, acc_min, acc_max;

      function int field(logic [31:0] x, int k);
         return int'((x >> (k * VB)) & 32'hF);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch %s: got %0h want %0h", what, got, want);
      endtask

      function void tally(longint unsigned p, longint unsigned m);
         acc_sum += p * m;
         acc_count += m;
         if (p < acc_min) acc_min = p;
         if (p > acc_max) acc_max = p;
      endfunction

      function void walk(int d, logic [255:0] live, longint unsigned mult);
         bit branch;
         bit [15:0] seen;
         int dom, known, c, e;
         logic [255:0] nxt;
         longint unsigned best, other;
         branch = 0;
         best = 0;
         for (int i = 0; i < used; i++)
            if (live[i])
               for (int j = d; j < null_total; j++)
                  if (field(tuples[i], null_cols[j]) != 15) branch = 1;
         if (!branch) begin
            for (int i = 0; i < used; i++)
               if (live[i] && weights[i] > best) best = weights[i];
            tally(best, mult * rest_prod[d]);
            return;
         end
         c = null_cols[d];
         dom = field(value_counts, c);
         seen = '0;
         for (int i = 0; i < used; i++) begin
            e = field(tuples[i], c);
            if (live[i] && e != 15 && e < dom) seen[e] = 1;
         end
         known = 0;
         for (int v = 0; v < dom; v++) begin
            if (seen[v]) begin
               known++;
               nxt = '0;
               for (int i = 0; i < used; i++) begin
                  e = field(tuples[i], c);
                  if (live[i] && (e == 15 || e == v)) nxt[i] = 1;
               end
               walk(d + 1, nxt, mult);
            end
         end
         other = longint'(dom == 0 ? 1 : dom) - known;
         if (other > 0) begin
            nxt = '0;
            for (int i = 0; i < used; i++)
               if (live[i] && field(tuples[i], c) == 15) nxt[i] = 1;
            walk(d + 1, nxt, mult * other);
         end
      endfunction

      function void set_reg(pdq_reg_type idx, logic [31:0] data);
         case (idx)
            REG_ENTRIES_IN_USE: entries_in_use = data[8:0];
            REG_COLUMN_COUNT: column_count = data[3:0];
            default: value_counts = data;
         endcase
      endfunction

      function void note(logic mode, logic [7:0] slot, logic [31:0] tuple, logic [15:0] w);
         int cols, dom;
         logic [255:0] live;
         degree_type r;
         if (mode == MODE_WRITE) begin
            tuples[slot] = tuple;
            weights[slot] = w;
            return;
         end
         cols = column_count > COLS ? COLS : column_count;
         used = entries_in_use > MAX_ENTRIES ? MAX_ENTRIES : entries_in_use;
         null_total = 0;
         for (int k = 0; k < cols; k++)
            if (field(tuple, k) == 15) null_cols[null_total++] = k;
         rest_prod[null_total] = 1;
         for (int d = null_total; d > 0; d--) begin
            dom = field(value_counts, null_cols[d - 1]);
            rest_prod[d - 1] = rest_prod[d] * longint'(dom == 0 ? 1 : dom);
         end
         live = '0;
         for (int i = 0; i < used; i++) begin
            live[i] = 1;
            for (int k = 0; k < cols; k++)
               if (field(tuple, k) != 15 && field(tuples[i], k) != 15 &&
                   field(tuple, k) != field(tuples[i], k)) live[i] = 0;
         end
         acc_sum = 0;
         acc_count = 0;
         acc_min = '1;
         acc_max = 0;
         walk(0, live, 1);
         if (acc_max == 0) acc_min = 0;
         r.average = acc_count != 0 ? 16'(acc_sum / acc_count) : 16'd0;
         r.minimum = 16'(acc_min);
         r.maximum = 16'(acc_max);
         r.fillings = 32'(acc_count);
         pending.push_back(r);
      endfunction

      task check(degree_type got);
         degree_type want;
         if (pending.size() == 0) begin
            report("unexpected result", got.fillings, 0);
            return;
         end
         want = pending.pop_front();
         if (got.average != want.average) report("average", got.average, want.average);
         if (got.minimum != want.minimum) report("minimum", got.minimum, want.minimum);
         if (got.maximum != want.maximum) report("maximum", got.maximum, want.maximum);
         if (got.fillings != want.fillings) report("fillings", got.fillings, want.fillings);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_mode = 0;
   logic [7:0]  req_entry_index = 0;
   logic [31:0] req_tuple_values = 0;
   logic [15:0] req_weight = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [15:0] rsp_average_possibility;
   logic [15:0] rsp_minimum_possibility;
   logic [15:0] rsp_maximum_possibility;
   logic [31:0] rsp_filling_count;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   degree_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int cycles = 0;
   int max_nulls = 8;

   possibility_degree_query uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check({rsp_average_possibility, rsp_minimum_possibility,
                      rsp_maximum_possibility, rsp_filling_count});
         rsp_stall <= $urandom_range(0, 99) < recv_idle;
      end
   end

   task send(logic mode, logic [7:0] slot, logic [31:0] tuple, logic [15:0] w);
      int gap;
      bit taken;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_entry_index <= slot;
      req_tuple_values <= tuple;
      req_weight <= w;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sb.note(mode, slot, tuple, w);
   endtask

   task drain;
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_reg(pdq_reg_type idx, logic [31:0] data);
      bit taken;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 0;
      sb.set_reg(idx, data);
   endtask

   task configure(logic [8:0] n, logic [3:0] cols, logic [31:0] counts);
      drain();
      write_reg(REG_ENTRIES_IN_USE, 32'(n));
      write_reg(REG_COLUMN_COUNT, 32'(cols));
      write_reg(REG_VALUE_COUNTS, counts);
   endtask

   function logic [31:0] entry_tuple();
      logic [31:0] t;
      for (int k = 0; k < 8; k++) begin
         if ($urandom_range(0, 99) < 25) t[k*4 +: 4] = 4'hF;
         else if ($urandom_range(0, 99) < 70) t[k*4 +: 4] = 4'($urandom_range(0, 3));
         else t[k*4 +: 4] = 4'($urandom_range(0, 14));
      end
      return t;
   endfunction

   function logic [31:0] query_tuple();
      logic [31:0] t;
      int n;
      n = 0;
      t = entry_tuple();
      for (int k = 0; k < 8; k++) begin
         if (t[k*4 +: 4] == 4'hF) t[k*4 +: 4] = 4'($urandom_range(0, 3));
         if (n < max_nulls && $urandom_range(0, 99) < 40) begin
            t[k*4 +: 4] = 4'hF;
            n++;
         end
      end
      return t;
   endfunction

   function logic [15:0] some_weight();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // load the slots that queries search
      for (int i = 0; i < 32; i++)
         send(MODE_WRITE, 8'(i), entry_tuple(), some_weight());
      send(MODE_QUERY, 0, 32'h00000000, 0);
      send(MODE_QUERY, 0, 32'hFFFFFFFF, 0);
      drain();
      write_reg(REG_ENTRIES_IN_USE, 32);
      send(MODE_WRITE, 8'd0, 32'h00000000, 16'hFFFF);
      send(MODE_WRITE, 8'd31, 32'hFFFFFFFF, 16'h0000);
      send(MODE_WRITE, 8'd1, 32'hEEEEEEEE, 16'h8001);
      send(MODE_QUERY, 0, 32'h00000000, 16'hFFFF);
      send(MODE_QUERY, 8'hFF, 32'hEEEEEEEE, 0);
      send(MODE_QUERY, 0, 32'hFFFFFF10, 0);
      send(MODE_QUERY, 0, 32'hFFFFFFFF, 0);
      send(MODE_QUERY, 0, 32'h1010FFFF, 0);
      configure(9'd32, 4'd15, 32'hFFFFFFFF);
      send(MODE_QUERY, 0, 32'hF0000000, 0);
      send(MODE_QUERY, 0, 32'h0000000F, 0);
      configure(9'd5, 4'd0, 32'h00000000);
      send(MODE_QUERY, 0, 32'h12345678, 0);
      configure(9'd5, 4'd4, 32'h00000000);
      send(MODE_QUERY, 0, 32'h0000FF0F, 0);
      send(MODE_QUERY, 0, 32'h0000E0D0, 0);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = phase == 0 ? 26 : phase == 1 ? 60 : 0;
         recv_idle = phase == 0 ? 60 : phase == 1 ? 26 : 0;
         for (int s = 0; s < 4; s++) begin
            case (s)
               0: begin
                  max_nulls = 1;
                  configure(9'd32, phase == 2 ? 4'd15 : 4'd8, 32'hFFFFFFFF);
               end
               1: begin
                  max_nulls = 8;
                  configure(9'd0, 4'($urandom_range(0, 8)), 32'h00000000);
               end
               default: begin
                  max_nulls = 4;
                  configure(9'($urandom_range(1, 24)), 4'($urandom_range(1, 8)), $urandom);
               end
            endcase
            for (int i = 0; i < 8; i++) begin
               if ($urandom_range(0, 99) < 30)
                  send(MODE_WRITE, 8'($urandom_range(0, 255)), entry_tuple(), some_weight());
               else
                  send(MODE_QUERY, 8'($urandom), query_tuple(), 16'($urandom));
               // let the table settle with nothing in flight once in a while
               if (i == 6 && s == 2) drain();
            end
         end
      end
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
